/* rtl/core/bcdcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcdcc_pkg
// Shared opcodes, register indexes and BCD helpers for the calendar clock.
// ----------------------------------------------------------------------------
package bcdcc_pkg;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_TICK = 2'd0;
    localparam t_opcode OP_SET  = 2'd1;
    localparam t_opcode OP_GET  = 2'd2;

    localparam logic CFG_ACCESS_EN = 1'b0;
    localparam logic CFG_LEAP_OFS  = 1'b1;

    localparam int PACKET_W = 56;
    localparam int CFG_W    = 2;

    localparam logic [6:0] SEC_LIMIT  = 7'd60;
    localparam logic [6:0] MIN_LIMIT  = 7'd60;
    localparam logic [5:0] HOURS_12   = 6'd12;
    localparam logic [5:0] HOURS_24   = 6'd24;
    localparam logic [7:0] YEAR_MAX   = 8'd99;
    localparam logic [4:0] MONTH_LAST = 5'd12;

    // Days in month 1..12; anything else counts as a 31-day month.
    function automatic logic [5:0] month_days(input logic [3:0] month);
        logic [5:0] d;
        unique case (month)
            4'd2:                      d = 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 6'd30;
            default:                   d = 6'd31;
        endcase
        return d;
    endfunction

    // Two BCD digits of a 7-bit value: quotient by 10 via reciprocal 205/2048,
    // exact for every 7-bit input.
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = {8'd0, v} * 15'd205;
        q    = prod[14:11];
        r    = v - 7'({3'd0, q} * 7'd10);
        return {q, r[3:0]};
    endfunction

    // tens * 10 + ones on two nibbles, 8-bit result.
    function automatic logic [7:0] dec2(input logic [3:0] tens, input logic [3:0] ones);
        return 8'({tens, 3'd0}) + 8'({tens, 1'b0}) + 8'(ones);
    endfunction

endpackage

/* rtl/core/bcd_calendar_clock.sv */
// ----------------------------------------------------------------------------
// bcd_calendar_clock
// BCD real-time clock and calendar with set/get packet access.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one beat per command:
//    tick (advance one second), set (load all fields from a 7-byte BCD
//    packet) or get (read the packet back). Set and get only act when
//    packet access is enabled; opcode 3 is dropped.
//  - Output channel (o_out_valid / i_out_ready) returns one beat per
//    enabled get; ticks and sets produce nothing.
//  - Every command is applied in the cycle it is accepted; a get result
//    is registered and appears in the output register in the cycle after.
//  - Throughput is one command per cycle while o_in_ready is high. The
//    output register is the only buffer: o_in_ready drops only while a
//    result is held and the receiver is stalling, and a new beat is taken
//    in the same cycle the held result leaves.
//  - Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//    (0 access enable, 1 leap offset) at the clock edge, no wait states.
//  - Reset (synchronous, i_rst_n low): 00-01-01, weekday 0, 12:00:00 AM
//    in 12-hour mode, access enabled, leap offset 0, output empty.
// ----------------------------------------------------------------------------
module bcd_calendar_clock
    import bcdcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic [PACKET_W-1:0] i_packet_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [PACKET_W-1:0] o_packet_out
);

    // configuration
    logic       r_access_en;
    logic [1:0] r_leap_ofs;

    // time and date counters (binary)
    logic [6:0] r_year,   n_year;
    logic [3:0] r_month,  n_month;
    logic [4:0] r_day,    n_day;
    logic [2:0] r_wday,   n_wday;
    logic [4:0] r_hour,   n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;
    logic       r_mode24, n_mode24;
    logic       r_pm,     n_pm;

    // result register
    logic                r_out_valid;
    logic [PACKET_W-1:0] r_packet;

    logic in_beat;
    logic do_get;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign in_beat      = i_in_valid && o_in_ready;
    assign do_get       = in_beat && (i_opcode == OP_GET) && r_access_en;
    assign o_out_valid  = r_out_valid;
    assign o_packet_out = r_packet;

    // ---------------------------------------------------------------- tick
    logic [6:0] sec_inc, min_inc;
    logic [5:0] hour_inc, day_inc, day_limit;
    logic [4:0] month_inc;
    logic [7:0] year_inc;
    logic       leap_feb;

    always_comb begin
        sec_inc   = 7'(r_second) + 7'd1;
        min_inc   = 7'(r_minute) + 7'd1;
        hour_inc  = 6'(r_hour) + 6'd1;
        day_inc   = 6'(r_day) + 6'd1;
        month_inc = 5'(r_month) + 5'd1;
        year_inc  = 8'(r_year) + 8'd1;
        day_limit = month_days(r_month);
        leap_feb  = (r_month == 4'd2) && (day_inc == 6'd29)
                    && (r_year[1:0] == 2'(3'd4 - 3'(r_leap_ofs)));
    end

    // ---------------------------------------------------------- packet I/O
    logic [7:0] b0, b1, b2, b3, b4, b5, b6;
    logic [7:0] g_year, g_month, g_day, g_hour, g_min, g_sec;
    logic [7:0] s_year, s_month, s_day, s_hour, s_min, s_sec;

    always_comb begin
        b0 = i_packet_in[55:48];
        b1 = i_packet_in[47:40];
        b2 = i_packet_in[39:32];
        b3 = i_packet_in[31:24];
        b4 = i_packet_in[23:16];
        b5 = i_packet_in[15:8];
        b6 = i_packet_in[7:0];

        // binary values of the packet digits, truncated at load
        s_year  = dec2(b0[7:4], b0[3:0]);
        s_month = dec2(b1[7:4], b1[3:0]);
        s_day   = dec2({2'b00, b2[5:4]}, b2[3:0]);
        s_hour  = dec2({2'b00, b3[1:0]}, b4[7:4]);
        s_min   = dec2(b4[3:0], b5[7:4]);
        s_sec   = dec2(b5[3:0], b6[7:4]);

        g_year  = bcd2(r_year);
        g_month = bcd2(7'(r_month));
        g_day   = bcd2(7'(r_day));
        g_hour  = bcd2(7'(r_hour));
        g_min   = bcd2(7'(r_minute));
        g_sec   = bcd2(7'(r_second));
    end

    // --------------------------------------------------------- next state
    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_wday   = r_wday;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_mode24 = r_mode24;
        n_pm     = r_pm;

        if (in_beat && i_opcode == OP_TICK) begin
            if (sec_inc < SEC_LIMIT) begin
                n_second = sec_inc[5:0];
            end else begin
                n_second = '0;
                if (min_inc < MIN_LIMIT) begin
                    n_minute = min_inc[5:0];
                end else begin
                    n_minute = '0;
                    // hour carry; date advances on midnight rollover only
                    if (r_mode24 && hour_inc < HOURS_24) begin
                        n_hour = hour_inc[4:0];
                        n_pm   = (hour_inc >= HOURS_12);
                    end else if (!r_mode24 && hour_inc < HOURS_12) begin
                        n_hour = hour_inc[4:0];
                    end else if (!r_mode24 && !r_pm) begin
                        n_hour = '0;
                        n_pm   = 1'b1;
                    end else begin
                        n_hour = '0;
                        n_pm   = 1'b0;
                        n_wday = (r_wday >= 3'd6) ? 3'd0 : r_wday + 3'd1;
                        if (day_inc <= day_limit || leap_feb) begin
                            n_day = day_inc[4:0];
                        end else begin
                            n_day = 5'd1;
                            if (month_inc <= MONTH_LAST) begin
                                n_month = month_inc[3:0];
                            end else begin
                                n_month = 4'd1;
                                n_year  = (year_inc > YEAR_MAX) ? 7'd0 : year_inc[6:0];
                            end
                        end
                    end
                end
            end
        end else if (in_beat && i_opcode == OP_SET && r_access_en) begin
            n_year   = s_year[6:0];
            n_month  = s_month[3:0];
            n_day    = s_day[4:0];
            n_wday   = b3[6:4];
            n_mode24 = b3[3];
            n_pm     = b3[2];
            n_hour   = s_hour[4:0];
            n_minute = s_min[5:0];
            n_second = s_sec[5:0];
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_en <= 1'b1;
            r_leap_ofs  <= 2'd0;
            r_year      <= 7'd0;
            r_month     <= 4'd1;
            r_day       <= 5'd1;
            r_wday      <= 3'd0;
            r_hour      <= 5'd0;
            r_minute    <= 6'd0;
            r_second    <= 6'd0;
            r_mode24    <= 1'b0;
            r_pm        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACCESS_EN: r_access_en <= i_cfg_data[0];
                    CFG_LEAP_OFS:  r_leap_ofs  <= i_cfg_data[1:0];
                    default:       r_access_en <= r_access_en;
                endcase
            end
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_wday   <= n_wday;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_mode24 <= n_mode24;
            r_pm     <= n_pm;
            if (do_get) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // get result is snapped from the state seen by this beat
    always_ff @(posedge i_clk) begin
        if (do_get) begin
            r_packet <= {g_year,
                         g_month,
                         r_leap_ofs, g_day[5:0],
                         1'b0, r_wday, r_mode24, (r_pm && !r_mode24), g_hour[5:4],
                         g_hour[3:0], g_min[7:4],
                         g_min[3:0], g_sec[7:4],
                         g_sec[3:0], 4'd0};
        end
    end

    // ---------------------------------------------------------- assertions
    a_tick_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_opcode == OP_TICK && !r_out_valid |=> !o_out_valid)
        else $error("tick produced an output beat");

    a_get_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_get |=> o_out_valid)
        else $error("enabled get lost its result");

    a_set_loads_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_opcode == OP_SET && r_access_en
        |=> r_mode24 == $past(i_packet_in[27]) && r_wday == $past(i_packet_in[30:28]))
        else $error("set did not load mode or weekday");

    a_locked_set_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_opcode == OP_SET && !r_access_en
        |=> $stable(r_year) && $stable(r_month) && $stable(r_day) && $stable(r_hour))
        else $error("set changed the calendar while access disabled");

endmodule
